>>> rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and helpers of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Largest animation length the sequencer is built for, and the cap on N
    localparam int MAX_FRAMES = 256;
    localparam int FRAME_CAP  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0] RAW_MAX = 10'd1023;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_PLAY   = 3'd1,
        KIND_PAUSE  = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_REWIND = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STARTED = 2'd1,
        EV_FRAME   = 2'd2,
        EV_ENDED   = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT     = 4'd0,
        REG_TICKS_PER_FRAME = 4'd1,
        REG_PINGPONG_MODE   = 4'd2,
        REG_REVERSE_MODE    = 4'd3
    } cfg_reg_t;

    // Effective configuration: N in 1..FRAME_CAP, P in 1..65535
    typedef struct packed {
        logic [8:0]  frames;
        logic [15:0] period;
        logic        pingpong;
        logic        reverse;
    } sfs_cfg_t;

    typedef struct packed {
        logic        playing;
        logic        paused;
        logic        looping;
        logic [15:0] tick_phase;
        logic [9:0]  raw_pos;
        logic [15:0] passes_done;
        logic [15:0] repeat_target;
        logic [7:0]  shown_frame;
    } sfs_state_t;

    typedef struct packed {
        logic [7:0] frame_index;
        logic       is_playing;
        logic       is_paused;
        event_t     event_res;
    } sfs_result_t;

    // Mirror a frame as N-1-f in reverse mode
    function automatic logic [7:0] mirror_frame(input logic [8:0] f,
                                                input logic [8:0] n,
                                                input logic       rev);
        logic [8:0] m;
        m = rev ? (n - 9'd1 - f) : f;
        return m[7:0];
    endfunction

endpackage

>>> rtl/sfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfs_cfg_regs
// Configuration registers; holds the effective frame count, period, ping-pong and reverse modes.
// ----------------------------------------------------------------------------
module sfs_cfg_regs import sfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output sfs_cfg_t              cfg
);

    sfs_cfg_t   cfg_reg;
    sfs_cfg_t   cfg_next;
    logic [8:0] fc;

    always_comb begin
        fc       = wr_data[8:0];
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_FRAME_COUNT: begin
                    if (fc == 9'd0) begin
                        cfg_next.frames = 9'd1;
                    end else if (fc > 9'(FRAME_CAP)) begin
                        cfg_next.frames = 9'(FRAME_CAP);
                    end else begin
                        cfg_next.frames = fc;
                    end
                end
                REG_TICKS_PER_FRAME: begin
                    cfg_next.period = (wr_data == '0) ? 16'd1 : wr_data;
                end
                REG_PINGPONG_MODE: cfg_next.pingpong = wr_data[0];
                REG_REVERSE_MODE:  cfg_next.reverse  = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frames   <= 9'd1;
            cfg_reg.period   <= 16'd1;
            cfg_reg.pingpong <= 1'b0;
            cfg_reg.reverse  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sfs_step.sv
// ----------------------------------------------------------------------------
// sfs_step
// Next-state and result logic for one tick or command.
// ----------------------------------------------------------------------------
module sfs_step import sfs_pkg::*; (
    input  sfs_cfg_t    cfg,
    input  sfs_state_t  state_cur,
    input  logic [2:0]  kind,
    input  logic [15:0] repeat_count,
    output sfs_state_t  state_nxt,
    output sfs_result_t result
);

    logic [9:0]  span;
    logic [9:0]  n_ext;
    logic [15:0] phase_inc;
    logic        phase_wrap;
    logic [9:0]  raw_inc;
    logic [9:0]  raw_new;
    logic [9:0]  idx;
    logic [9:0]  fold;
    logic [8:0]  n_last;
    logic        can_repeat;

    assign n_ext      = {1'b0, cfg.frames};
    assign span       = cfg.pingpong ? {cfg.frames, 1'b0} : n_ext;
    assign n_last     = cfg.frames - 9'd1;
    assign phase_inc  = state_cur.tick_phase + 16'd1;
    assign phase_wrap = (phase_inc >= cfg.period) || (phase_inc == '0);
    assign raw_inc    = (state_cur.raw_pos == RAW_MAX) ? RAW_MAX
                                                       : state_cur.raw_pos + 10'd1;
    assign raw_new    = phase_wrap ? raw_inc : state_cur.raw_pos;

    // Raw index is ceil(e/P)-1; pinned at the saturated position
    always_comb begin
        if (raw_new == RAW_MAX) begin
            idx = RAW_MAX;
        end else if (phase_wrap) begin
            idx = raw_new - 10'd1;
        end else begin
            idx = raw_new;
        end
    end

    // Fold the backward half of a ping-pong pass
    assign fold = (idx >= n_ext) ? ({cfg.frames, 1'b0} - 10'd1 - idx) : idx;

    assign can_repeat = (state_cur.repeat_target != '0) &&
                        (state_cur.passes_done < state_cur.repeat_target);

    always_comb begin
        event_t ev;
        state_nxt = state_cur;
        ev        = EV_NONE;
        unique case (kind)
            KIND_TICK: begin
                if (state_cur.playing && !state_cur.paused) begin
                    state_nxt.tick_phase = phase_wrap ? 16'd0 : phase_inc;
                    state_nxt.raw_pos    = raw_new;
                    if (idx < span) begin
                        state_nxt.shown_frame = mirror_frame(fold[8:0], cfg.frames,
                                                             cfg.reverse);
                        ev = EV_FRAME;
                    end else if (state_cur.looping || can_repeat) begin
                        // Restart the pass
                        state_nxt.tick_phase  = 16'd0;
                        state_nxt.raw_pos     = 10'd0;
                        state_nxt.shown_frame = mirror_frame(9'd0, cfg.frames,
                                                             cfg.reverse);
                        if (!state_cur.looping && state_cur.passes_done != 16'hFFFF) begin
                            state_nxt.passes_done = state_cur.passes_done + 16'd1;
                        end
                    end else begin
                        state_nxt.passes_done = 16'd1;
                        state_nxt.playing     = 1'b0;
                        state_nxt.shown_frame = mirror_frame(
                            cfg.pingpong ? 9'd0 : n_last, cfg.frames, cfg.reverse);
                        ev = EV_ENDED;
                    end
                end
            end
            KIND_PLAY: begin
                state_nxt.repeat_target = repeat_count;
                state_nxt.looping       = (repeat_count == '0);
                state_nxt.tick_phase    = 16'd0;
                state_nxt.raw_pos       = 10'd0;
                state_nxt.playing       = 1'b1;
                if (cfg.reverse) begin
                    state_nxt.shown_frame = n_last[7:0];
                end
                ev = EV_STARTED;
            end
            KIND_PAUSE:  state_nxt.paused  = !state_cur.paused;
            KIND_STOP:   state_nxt.playing = 1'b0;
            KIND_REWIND: state_nxt.shown_frame = cfg.reverse ? n_last[7:0] : 8'd0;
            default: ;
        endcase
        result.frame_index = state_nxt.shown_frame;
        result.is_playing  = state_nxt.playing;
        result.is_paused   = state_nxt.paused;
        result.event_res   = ev;
    end

endmodule

>>> rtl/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Frame-index sequencer for sprite animation driven by ticks and commands.
// ----------------------------------------------------------------------------
// Each input transaction is a tick or a command (play, pause toggle, stop,
// rewind) and yields exactly one result transaction with the frame to show,
// the playing and paused flags and an event code (none, started, frame
// updated, ended). The block takes one transaction every clock cycle while
// s_ready is high, passing each one through the input register and then
// the result register. The sequencer state is updated in the same cycle
// the item moves into the result register, so back-to-back items see
// each other's effects with no bubble. A result that waits for m_ready
// holds the input register, and s_ready drops only when the result and
// input registers are both full and m_ready is low. Configuration writes
// (frame count, ticks per frame, ping-pong, reverse) are always accepted
// and should be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer import sfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_kind,
    input  logic [15:0]           s_repeat_count,
    // Result transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_frame_index,
    output logic                  m_is_playing,
    output logic                  m_is_paused,
    output logic [1:0]            m_event_res,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sfs_cfg_t    cfg;
    sfs_state_t  state_reg;
    sfs_state_t  state_next;
    sfs_result_t step_result;

    logic        in_vld_reg;
    logic [2:0]  in_kind_reg;
    logic [15:0] in_rep_reg;
    logic        out_vld_reg;
    sfs_result_t out_reg;
    logic        advance;

    // Configuration never stalls
    assign cfg_ready = 1'b1;

    sfs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held item when the result register is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_rep_reg  <= s_repeat_count;
        end
    end

    sfs_step u_step (
        .cfg          (cfg),
        .state_cur    (state_reg),
        .kind         (in_kind_reg),
        .repeat_count (in_rep_reg),
        .state_nxt    (state_next),
        .result       (step_result)
    );

    // Commit the sequencer state only when the item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.playing       <= 1'b0;
            state_reg.paused        <= 1'b0;
            state_reg.looping       <= 1'b0;
            state_reg.tick_phase    <= 16'd0;
            state_reg.raw_pos       <= 10'd0;
            state_reg.passes_done   <= 16'd1;
            state_reg.repeat_target <= 16'd1;
            state_reg.shown_frame   <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while the consumer stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_frame_index = out_reg.frame_index;
    assign m_is_playing  = out_reg.is_playing;
    assign m_is_paused   = out_reg.is_paused;
    assign m_event_res   = out_reg.event_res;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A stalled result must keep the waiting item in the input register
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |=> in_vld_reg)
        else $error("input item dropped while result stalled");

    // An ended pass always leaves the sequencer stopped
    a_end_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_ENDED) |-> !m_is_playing)
        else $error("ended event while still playing");

    // Started and frame-updated events are only reported while playing
    a_start_plays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_event_res == EV_STARTED) || (m_event_res == EV_FRAME))
        |-> m_is_playing)
        else $error("start or frame event while not playing");

    // The playing flag can only rise by a play command
    a_play_source: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !state_reg.playing && state_next.playing
        |-> in_kind_reg == KIND_PLAY)
        else $error("playing set without a play command");

endmodule

>>> test/sfs_frame_checker.sv
// ----------------------------------------------------------------------------
// sfs_frame_checker
// Watches the configuration, input and result channels of the sprite frame
// sequencer. It keeps its own copy of the sequencer state, predicts one
// result for every accepted input transaction and compares each accepted
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sfs_frame_checker import sfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [2:0]            s_kind,
    input  logic [15:0]           s_repeat_count,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_frame_index,
    input  logic                  m_is_playing,
    input  logic                  m_is_paused,
    input  logic [1:0]            m_event_res,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register values as written, and the predicted sequencer state
    sfs_cfg_t    regs;
    sfs_state_t  seq;
    sfs_result_t expected_frames[$];

    function automatic void reset_sequencer();
        regs.frames   = 9'd1;
        regs.period   = 16'd1;
        regs.pingpong = 1'b0;
        regs.reverse  = 1'b0;
        seq = '0;
        seq.passes_done   = 16'd1;
        seq.repeat_target = 16'd1;
    endfunction

    // Zero frames counts as one; the length is capped at the build limit
    function automatic int frame_total();
        int n;
        n = (regs.frames == 9'd0) ? 1 : int'(regs.frames);
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        if (n > 256) n = 256;
        return n;
    endfunction

    function automatic logic [7:0] shown_as(input int f);
        int g;
        g = regs.reverse ? (frame_total() - 1 - f) : f;
        return g[7:0];
    endfunction

    function automatic event_t advance_tick();
        int n, p, span, idx, f;
        n    = frame_total();
        p    = (regs.period == 16'd0) ? 1 : int'(regs.period);
        span = regs.pingpong ? 2 * n : n;
        if (!seq.playing || seq.paused) return EV_NONE;

        // A phase left at or above a shrunk period carries on this tick
        seq.tick_phase = seq.tick_phase + 16'd1;
        if (int'(seq.tick_phase) >= p || seq.tick_phase == 16'd0) begin
            seq.tick_phase = '0;
            if (seq.raw_pos != RAW_MAX) seq.raw_pos = seq.raw_pos + 10'd1;
        end
        idx = (seq.tick_phase == 16'd0) ? int'(seq.raw_pos) - 1 : int'(seq.raw_pos);
        if (seq.raw_pos == RAW_MAX) idx = 1023;

        if (idx < span) begin
            f = (idx >= n) ? 2 * n - 1 - idx : idx;
            seq.shown_frame = shown_as(f);
            return EV_FRAME;
        end
        if (seq.looping || (seq.repeat_target != 16'd0 &&
                            seq.passes_done < seq.repeat_target)) begin
            if (!seq.looping && seq.passes_done != 16'hFFFF)
                seq.passes_done = seq.passes_done + 16'd1;
            seq.tick_phase  = '0;
            seq.raw_pos     = '0;
            seq.shown_frame = shown_as(0);
            return EV_NONE;
        end
        seq.passes_done = 16'd1;
        seq.playing     = 1'b0;
        seq.shown_frame = shown_as(regs.pingpong ? 0 : n - 1);
        return EV_ENDED;
    endfunction

    function automatic sfs_result_t predict_frame(input logic [2:0] kind,
                                                  input logic [15:0] reps);
        sfs_result_t r;
        event_t      ev;
        ev = EV_NONE;
        case (kind)
            KIND_TICK: begin
                ev = advance_tick();
            end
            KIND_PLAY: begin
                seq.repeat_target = reps;
                seq.looping       = (reps == 16'd0);
                seq.tick_phase    = '0;
                seq.raw_pos       = '0;
                seq.playing       = 1'b1;
                if (regs.reverse) seq.shown_frame = 8'(frame_total() - 1);
                ev = EV_STARTED;
            end
            KIND_PAUSE: begin
                seq.paused = !seq.paused;
            end
            KIND_STOP: begin
                seq.playing = 1'b0;
            end
            KIND_REWIND: begin
                seq.shown_frame = regs.reverse ? 8'(frame_total() - 1) : 8'd0;
            end
            default: begin
            end
        endcase
        r.frame_index = seq.shown_frame;
        r.is_playing  = seq.playing;
        r.is_paused   = seq.paused;
        r.event_res   = ev;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want,
                                        input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        sfs_result_t want;
        if (!aresetn) begin
            reset_sequencer();
            expected_frames.delete();
            mismatches  = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_COUNT:     regs.frames   = cfg_data[8:0];
                    REG_TICKS_PER_FRAME: regs.period   = cfg_data[15:0];
                    REG_PINGPONG_MODE:   regs.pingpong = cfg_data[0];
                    REG_REVERSE_MODE:    regs.reverse  = cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                expected_frames.insert(expected_frames.size(),
                                       predict_frame(s_kind, s_repeat_count));
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result expected none, got frame %0d playing %0d",
                             $time, m_frame_index, m_is_playing);
                    $display("%0t: paused %0d event %0d",
                             $time, m_is_paused, m_event_res);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_index", int'(want.frame_index), int'(m_frame_index));
                    check_field("is_playing", int'(want.is_playing), int'(m_is_playing));
                    check_field("is_paused", int'(want.is_paused), int'(m_is_paused));
                    check_field("event_res", int'(want.event_res), int'(m_event_res));
                end
            end
            outstanding <= expected_frames.size();
        end
    end

endmodule

>>> test/tb_sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer
// Self-checking testbench for the sprite frame sequencer.
// ----------------------------------------------------------------------------
// A directed opening covers idle ticks, unused kinds, pause toggles while
// stopped, rewind, counted and endless play, and the zero and oversized
// register values. Two mid-play register changes follow: a long ping-pong
// pass shrunk under a held position, and a tick phase carried over a
// shortened period. Random phases then reprogram every register and send
// mostly play-and-tick sequences with stray commands mixed in. Both sides
// stall at random except for a quiet stretch. A separate checker predicts
// and compares; this module only drives and reports the verdict.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer import sfs_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 28;
    localparam int CYCLE_LIMIT = 400_000;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_kind         = '0;
    logic [15:0]           s_repeat_count = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [7:0]            m_frame_index;
    logic                  m_is_playing;
    logic                  m_is_paused;
    logic [1:0]            m_event_res;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    int                    mismatches;
    int                    outstanding;

    // Set during the stretch where neither side stalls
    bit quiet = 1'b0;
    int cycles = 0;

    sprite_frame_sequencer u_dut (.*);

    sfs_frame_checker u_checker (.*);

    always #2 aclk = ~aclk;

    // Abort a run that hangs on a handshake or a missing result
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_sprite_frame_sequencer: FAIL");
            $finish;
        end
    end

    // Stall the result side at random, never inside the quiet stretch
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one transaction and hold it until accepted. Valid stays high on
    // return, so a following transaction goes out with no bubble; drop valid
    // only when idling or draining.
    task automatic send_transaction(input logic [2:0] kind, input logic [15:0] reps);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_repeat_count <= reps;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all four registers; unused upper data bits carry junk half the time
    task automatic write_config(input logic [8:0] frames, input logic [15:0] period,
                                input logic pingpong, input logic reverse);
        logic [15:0] junk;
        junk = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        write_reg(REG_FRAME_COUNT, {junk[15:9], frames});
        write_reg(REG_TICKS_PER_FRAME, period);
        write_reg(REG_PINGPONG_MODE, {junk[15:1], pingpong});
        write_reg(REG_REVERSE_MODE, {junk[14:0], reverse});
        cfg_valid <= 1'b0;
    endtask

    // Mostly endless or short counted plays, now and then any count at all
    function automatic logic [15:0] play_reps();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 16'd0;
        if (pick < 85) return 16'($urandom_range(1, 4));
        return 16'($urandom);
    endfunction

    function automatic logic [8:0] pick_frames();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            3:       return 9'($urandom_range(7, 255));
            default: return 9'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3:       return 16'($urandom_range(4, 20));
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // Ticks dominate so passes run to their end; commands break in now and then
    task automatic random_command();
        int          pick;
        logic [15:0] junk;
        pick = $urandom_range(0, 99);
        junk = 16'($urandom);
        if (pick < 68)      send_transaction(KIND_TICK, junk);
        else if (pick < 76) send_transaction(KIND_PLAY, play_reps());
        else if (pick < 81) send_transaction(KIND_PAUSE, junk);
        else if (pick < 85) send_transaction(KIND_STOP, junk);
        else if (pick < 91) send_transaction(KIND_REWIND, junk);
        else                send_transaction(3'($urandom_range(5, 7)), junk);
    endtask

    initial begin
        int count;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: one frame, one tick. Idle ticks, unused kinds and
        // a pause toggle while stopped must leave the frame alone.
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(3'd5, 16'hFFFF);
        send_transaction(3'd6, 16'h5555);
        send_transaction(3'd7, 16'hAAAA);
        send_transaction(KIND_PAUSE, 16'h0000);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_PAUSE, 16'h0000);
        send_transaction(KIND_REWIND, 16'h0000);
        drain();

        // Zero frame count and zero period both act as one
        write_config(9'd0, 16'd0, 1'b0, 1'b0);
        send_transaction(KIND_PLAY, 16'hFFFF);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_STOP, 16'h0000);
        send_transaction(KIND_PLAY, 16'h0000);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_STOP, 16'h0000);
        drain();

        // Oversized frame count caps at 256; longest period; reverse ping-pong
        write_config(9'd511, 16'hFFFF, 1'b1, 1'b1);
        send_transaction(KIND_PLAY, 16'd1);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_PAUSE, 16'h0000);
        send_transaction(KIND_TICK, 16'h0000);
        send_transaction(KIND_PAUSE, 16'h0000);
        send_transaction(KIND_REWIND, 16'h0000);
        send_transaction(KIND_STOP, 16'h0000);
        drain();

        // Run deep into a long ping-pong pass, then shrink the animation so
        // the held position lies past the new span and ends the pass
        write_config(9'd256, 16'd1, 1'b1, 1'b0);
        send_transaction(KIND_PLAY, 16'd1);
        repeat (300) send_transaction(KIND_TICK, 16'($urandom));
        drain();
        write_config(9'd4, 16'd1, 1'b1, 1'b0);
        repeat (3) send_transaction(KIND_TICK, 16'($urandom));
        drain();

        // Build up a tick phase under the longest period, then shorten the
        // period so the phase carries; flip reverse off under a held frame
        write_config(9'd8, 16'hFFFF, 1'b0, 1'b1);
        send_transaction(KIND_PLAY, 16'd0);
        repeat (20) send_transaction(KIND_TICK, 16'($urandom));
        drain();
        write_config(9'd8, 16'd3, 1'b0, 1'b0);
        repeat (12) send_transaction(KIND_TICK, 16'($urandom));
        drain();

        // Random phases: reprogram, usually start a play, then mixed commands.
        // State carries across phases, so registers also change mid-play.
        for (int phase = 0; phase < 22; phase++) begin
            quiet = (phase >= 8 && phase < 12);
            write_config(pick_frames(), pick_period(), 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 9) < 7) send_transaction(KIND_PLAY, play_reps());
            count = $urandom_range(16, 26);
            repeat (count) random_command();
            drain();
        end
        quiet = 1'b0;

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_sprite_frame_sequencer: PASS");
        end else begin
            $display("tb_sprite_frame_sequencer: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sfs_pkg.sv
rtl/sfs_cfg_regs.sv
rtl/sfs_step.sv
rtl/sprite_frame_sequencer.sv
test/sfs_frame_checker.sv
test/tb_sprite_frame_sequencer.sv
